// ===== design/sobel_pkg.sv =====
// Shared types and constants for the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_pkg;

    localparam int PIXEL_W      = 8;
    localparam int THRESH_W     = 10;
    localparam int DIM_W        = 12;
    localparam int CENTER_COL_W = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int SUM_W        = 10;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd100;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 12'd180;
    localparam logic [DIM_W-1:0]    HEIGHT_RESET = 12'd120;
    localparam logic [DIM_W-1:0]    MIN_DIM      = 12'd3;

    localparam logic [PIXEL_W-1:0]  EDGE_ON      = 8'd255;
    localparam logic [PIXEL_W-1:0]  EDGE_OFF     = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]      edge_res;
        logic [DIM_W-1:0]        center_row;
        logic [CENTER_COL_W-1:0] center_col;
        logic                    frame_last;
    } res_t;

endpackage

// ===== design/sobel_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sobel_edge_threshold.sv =====
// Top level of the 3x3 vertical Sobel edge detector with threshold.
//
// Pixels arrive on pixel / pixel_valid / pixel_ready in raster order, one
// transaction per pixel; the frame restarts after its last pixel. Each
// interior pixel position yields one result transaction on result_valid /
// result_ready carrying edge_res (255 or 0), the centre coordinates and
// frame_last; border positions yield nothing.
// Throughput is one pixel per clock while pixel_ready stays high. On acceptance
// the line buffer is read and the stage 1 registers are loaded; the gradient is
// then formed combinationally from them and registered into the result queue.
// The line buffer is a 16-bit wide RAM of MAX_WIDTH words holding the two
// previous lines side by side; it is not cleared.
// Results wait in a three-entry queue; a stalled receiver fills it and
// pixel_ready drops until space returns, so nothing is lost.
// Registers are written on cfg_valid / cfg_ready (always ready) by index:
// threshold, image_width, image_height. Writes are meant for idle periods.
// Reset clears the counters, window and queue and restores register
// defaults (threshold 100, 180 x 120 frame).
`timescale 1ns / 1ps

module sobel_edge_threshold #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [sobel_pkg::PIXEL_W-1:0]     pixel,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [sobel_pkg::PIXEL_W-1:0]     edge_res,
    output logic [sobel_pkg::DIM_W-1:0]       center_row,
    output logic [sobel_pkg::CENTER_COL_W-1:0] center_col,
    output logic                              frame_last
);

    import sobel_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LIM_W     = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int CC_W      = (COL_W > CENTER_COL_W) ? COL_W : CENTER_COL_W;
    localparam int RES_DEPTH = 3;
    localparam int PTR_W     = 2;
    localparam int CNT_W     = 3;

    // configuration
    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:    threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_IMAGE_WIDTH:  width_reg     <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg    <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective frame size
    logic [LIM_W-1:0] width_ext;
    logic [LIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;

    always_comb
    begin
        width_ext = LIM_W'(width_reg);
        priority if (width_reg < MIN_DIM)
        begin
            eff_width = LIM_W'(MIN_DIM);
        end
        else if (width_ext > LIM_W'(MAX_WIDTH))
        begin
            eff_width = LIM_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        eff_height = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    end

    // position counters, stage 0
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] row_next;
    logic             col_wrap;
    logic             row_wrap;
    logic             interior;
    logic             accept;

    assign accept   = pixel_valid && pixel_ready;
    assign col_wrap = (LIM_W'(col_reg) + LIM_W'(1)) >= eff_width;
    assign row_wrap = ({1'b0, row_reg} + (DIM_W + 1)'(1)) >= {1'b0, eff_height};
    assign interior = (row_reg >= DIM_W'(2)) && (LIM_W'(col_reg) >= LIM_W'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + DIM_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 registers
    logic                    s1_valid_reg;
    logic                    s1_interior_reg;
    logic                    s1_last_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [PIXEL_W-1:0]      s1_pixel_reg;
    logic [DIM_W-1:0]        s1_row_out_reg;
    logic [CENTER_COL_W-1:0] s1_col_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_interior_reg <= interior;
            s1_last_reg     <= col_wrap && row_wrap;
            s1_col_reg      <= col_reg;
            s1_pixel_reg    <= pixel;
            s1_row_out_reg  <= row_reg - DIM_W'(1);
            s1_col_out_reg  <= CENTER_COL_W'(CC_W'(col_reg) - CC_W'(1));
        end
    end

    // line buffer: upper byte previous line, lower byte the line before
    logic [2*PIXEL_W-1:0] line_rdata;
    logic [PIXEL_W-1:0]   line_mid;
    logic [PIXEL_W-1:0]   line_top;

    assign line_mid = line_rdata[2*PIXEL_W-1:PIXEL_W];
    assign line_top = line_rdata[PIXEL_W-1:0];

    sobel_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({s1_pixel_reg, line_mid}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // window: two most recent columns of the top and bottom rows
    logic [PIXEL_W-1:0] top_old_reg;
    logic [PIXEL_W-1:0] top_new_reg;
    logic [PIXEL_W-1:0] bot_old_reg;
    logic [PIXEL_W-1:0] bot_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_old_reg <= '0;
            top_new_reg <= '0;
            bot_old_reg <= '0;
            bot_new_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            top_old_reg <= top_new_reg;
            top_new_reg <= line_top;
            bot_old_reg <= bot_new_reg;
            bot_new_reg <= s1_pixel_reg;
        end
    end

    logic [SUM_W-1:0]        top_sum;
    logic [SUM_W-1:0]        bot_sum;
    logic signed [SUM_W:0]   grad;
    logic [SUM_W-1:0]        grad_mag;
    res_t                    s1_res;

    always_comb
    begin
        top_sum  = SUM_W'(top_old_reg) + SUM_W'({top_new_reg, 1'b0}) + SUM_W'(line_top);
        bot_sum  = SUM_W'(bot_old_reg) + SUM_W'({bot_new_reg, 1'b0}) + SUM_W'(s1_pixel_reg);
        grad     = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        grad_mag = grad[SUM_W] ? SUM_W'(-grad) : grad[SUM_W-1:0];
        s1_res.edge_res   = (grad_mag > threshold_reg) ? EDGE_ON : EDGE_OFF;
        s1_res.center_row = s1_row_out_reg;
        s1_res.center_col = s1_col_out_reg;
        s1_res.frame_last = s1_last_reg;
    end

    // result queue
    res_t             res_q_reg [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;
    res_t             head;

    assign push = s1_valid_reg && s1_interior_reg;
    assign pop  = result_valid && result_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_q_reg[wr_ptr_reg] <= s1_res;
        end
    end

    // room for the transaction in stage 1 plus one more
    assign pixel_ready  = (cnt_reg + CNT_W'(s1_valid_reg)) < CNT_W'(RES_DEPTH);

    assign result_valid = cnt_reg != '0;
    assign head         = res_q_reg[rd_ptr_reg];
    assign edge_res     = head.edge_res;
    assign center_row   = head.center_row;
    assign center_col   = head.center_col;
    assign frame_last   = head.frame_last;

endmodule
